FILE: hw/rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg - shared types and helpers of the json string escaper
// character codes, utf-8 lead byte checks, escape tables and the
// descriptor that carries one item's output text between the stages
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_D   = 8'h64;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [7:0] BYTE_NUL  = 8'h00;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_CTRL_END = 8'h20;

    // index of the last character of the replacement text backslash u f f f d
    localparam logic [2:0] FFFD_LAST = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       string_start;
        logic       string_end;
    } item_t;

    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic [2:0]      len;
    } esc_t;

    // output text of one item: opening quote, replacements, tail, closing quote
    typedef struct packed {
        logic            open;
        logic [2:0]      nf;
        logic [5:0][7:0] tail;
        logic [2:0]      tail_len;
        logic            close;
    } desc_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN,
        PH_FFFD,
        PH_TAIL,
        PH_CLOSE
    } phase_t;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        hex_char = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
    endfunction

    // sequence length from the lead byte, zero for a byte that cannot lead
    function automatic logic [2:0] lead_need(input logic [7:0] b);
        if (b < 8'h80) begin
            lead_need = 3'd1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            lead_need = 3'd2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            lead_need = 3'd3;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            lead_need = 3'd4;
        end else begin
            lead_need = 3'd0;
        end
    endfunction

    // continuation byte check, the second byte has a lead specific range
    function automatic logic byte_fits(input logic [7:0] lead, input logic [1:0] pos,
                                       input logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (pos == 2'd1) begin
            if (lead == 8'hE0) lo = 8'hA0;
            if (lead == 8'hED) hi = 8'h9F;
            if (lead == 8'hF0) lo = 8'h90;
            if (lead == 8'hF4) hi = 8'h8F;
        end
        byte_fits = (c >= lo) && (c <= hi);
    endfunction

    // escape of a non-nul ascii byte
    function automatic esc_t ascii_escape(input logic [7:0] c);
        esc_t e;
        e.bytes = '0;
        e.len   = 3'd2;
        e.bytes[0] = CH_BSLASH;
        case (c)
            CH_QUOTE:  e.bytes[1] = CH_QUOTE;
            CH_BSLASH: e.bytes[1] = CH_BSLASH;
            BYTE_LF:   e.bytes[1] = CH_LC_N;
            BYTE_CR:   e.bytes[1] = CH_LC_R;
            BYTE_TAB:  e.bytes[1] = CH_LC_T;
            default: begin
                if (c < BYTE_CTRL_END) begin
                    e.bytes[1] = CH_LC_U;
                    e.bytes[2] = CH_ZERO;
                    e.bytes[3] = CH_ZERO;
                    e.bytes[4] = hex_char(c[7:4]);
                    e.bytes[5] = hex_char(c[3:0]);
                    e.len      = 3'd6;
                end else begin
                    e.bytes[0] = c;
                    e.len      = 3'd1;
                end
            end
        endcase
        ascii_escape = e;
    endfunction

    function automatic logic [7:0] fffd_char(input logic [2:0] idx);
        case (idx)
            3'd0:    fffd_char = CH_BSLASH;
            3'd1:    fffd_char = CH_LC_U;
            3'd2:    fffd_char = CH_LC_F;
            3'd3:    fffd_char = CH_LC_F;
            3'd4:    fffd_char = CH_LC_F;
            3'd5:    fffd_char = CH_LC_D;
            default: fffd_char = 8'h00;
        endcase
    endfunction

    // next phase with something to send, idle once the text is used up
    function automatic phase_t next_phase(input desc_t d, input phase_t cur);
        logic   past_idle;
        logic   past_open;
        logic   past_fffd;
        logic   past_tail;
        phase_t res;
        past_idle = (cur != PH_IDLE);
        past_open = past_idle && (cur != PH_OPEN);
        past_fffd = past_open && (cur != PH_FFFD);
        past_tail = past_fffd && (cur != PH_TAIL);
        if (!past_idle && d.open) begin
            res = PH_OPEN;
        end else if (!past_open && d.nf != 3'd0) begin
            res = PH_FFFD;
        end else if (!past_fffd && d.tail_len != 3'd0) begin
            res = PH_TAIL;
        end else if (!past_tail && d.close) begin
            res = PH_CLOSE;
        end else begin
            res = PH_IDLE;
        end
        next_phase = res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jse_classify.sv
// ----------------------------------------------------------------------------
// jse_classify - utf-8 check and escape decision for one item
// turns the held partial sequence and one item into an output descriptor
// and the partial sequence left behind
// ----------------------------------------------------------------------------
`default_nettype none

module jse_classify (
    input  wire jse_pkg::item_t     item,
    input  wire logic [1:0]         pend_cnt,
    input  wire logic [2:0][7:0]    pend_bytes,
    output jse_pkg::desc_t          desc,
    output logic [1:0]              pend_cnt_next,
    output logic [2:0][7:0]         pend_bytes_next
);

    logic [1:0]     p;
    logic [2:0]     need_q0;
    logic [2:0]     need_b;
    logic           fits;
    logic           alone;
    jse_pkg::esc_t  esc;

    always_comb begin
        p       = item.string_start ? 2'd0 : pend_cnt;
        need_q0 = jse_pkg::lead_need(pend_bytes[0]);
        need_b  = jse_pkg::lead_need(item.data_byte);
        fits    = jse_pkg::byte_fits(pend_bytes[0], p, item.data_byte);
        esc     = jse_pkg::ascii_escape(item.data_byte);

        desc.open     = item.string_start;
        desc.close    = item.string_end;
        desc.nf       = 3'd0;
        desc.tail     = '0;
        desc.tail_len = 3'd0;
        pend_cnt_next   = p;
        pend_bytes_next = pend_bytes;
        alone = 1'b0;

        if (item.has_byte) begin
            if (p != 2'd0 && fits) begin
                if ({1'b0, p} + 3'd1 == need_q0) begin
                    // sequence complete, pass it through raw
                    for (int i = 0; i < 4; i++) begin
                        if (i < int'(p)) begin
                            desc.tail[i] = pend_bytes[i];
                        end else if (i == int'(p)) begin
                            desc.tail[i] = item.data_byte;
                        end
                    end
                    desc.tail_len = {1'b0, p} + 3'd1;
                    pend_cnt_next = 2'd0;
                end else if (item.string_end) begin
                    desc.nf = {1'b0, p} + 3'd1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (i == int'(p)) pend_bytes_next[i] = item.data_byte;
                    end
                    pend_cnt_next = p + 2'd1;
                end
            end else begin
                // held bytes fail one by one, then the new byte is checked afresh
                desc.nf = {1'b0, p};
                alone   = 1'b1;
            end
        end else if (item.string_end) begin
            desc.nf = {1'b0, p};
        end

        if (alone) begin
            case (need_b)
                3'd1: begin
                    if (item.data_byte == jse_pkg::BYTE_NUL) begin
                        desc.nf = desc.nf + 3'd1;
                    end else begin
                        desc.tail     = esc.bytes;
                        desc.tail_len = esc.len;
                    end
                    pend_cnt_next = 2'd0;
                end
                3'd2, 3'd3, 3'd4: begin
                    if (item.string_end) begin
                        desc.nf = desc.nf + 3'd1;
                    end else begin
                        pend_bytes_next[0] = item.data_byte;
                    end
                    pend_cnt_next = 2'd1;
                end
                default: begin
                    desc.nf = desc.nf + 3'd1;
                    pend_cnt_next = 2'd0;
                end
            endcase
        end

        if (item.string_end) pend_cnt_next = 2'd0;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/json_string_escaper_utf8.sv
// ----------------------------------------------------------------------------
// json_string_escaper_utf8 - json string literal writer with utf-8 repair
// takes raw string bytes and sends the quoted, escaped json text one byte
// per transfer, replacing broken utf-8 and nul bytes by \ufffd
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                    marker
//  s_        in         tdata: data_byte, tuser: has_byte, start   tlast: string_end
//  m_        out        tdata: out_byte                            tlast: closing quote
//
// one output byte per cycle while m_tready is high; an item that yields n
// bytes (0 to 26) holds the output stage until its last byte is taken, an
// item with no bytes skips it, so plain text runs at one input byte per cycle
// an input register and a descriptor register separate the two sides, so the
// next input transfer is taken while the current text is still being sent
// reset clears both stages and the held utf-8 byte count
// a stall on m_ holds the output byte; s_tready drops only once the input
// register is full behind a busy output stage
//
`default_nettype none

module json_string_escaper_utf8 (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] data_byte
    input  wire logic [1:0] s_tuser,    // [0] has_byte, [1] string_start
    input  wire logic       s_tlast,    // string_end

    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] out_byte
    output logic            m_tlast     // out_last, on the closing quote
);

    // input register
    logic               a_valid_reg, a_valid_next;
    jse_pkg::item_t     a_item_reg, a_item_next;

    // output stage: descriptor and position within its text
    jse_pkg::desc_t     desc_reg, desc_next;
    jse_pkg::phase_t    phase_reg, phase_next;
    logic [2:0]         rep_reg, rep_next;
    logic [2:0]         chr_reg, chr_next;

    // held bytes of an unfinished utf-8 sequence
    logic [1:0]         pend_cnt_reg, pend_cnt_next;
    logic [2:0][7:0]    pend_bytes_reg, pend_bytes_next;

    jse_pkg::desc_t     cls_desc;
    logic [1:0]         cls_cnt;
    logic [2:0][7:0]    cls_bytes;

    logic               s_xfer;
    logic               m_xfer;
    logic               phase_end;
    jse_pkg::phase_t    phase_after;
    logic               load;

    jse_classify u_classify (
        .item            (a_item_reg),
        .pend_cnt        (pend_cnt_reg),
        .pend_bytes      (pend_bytes_reg),
        .desc            (cls_desc),
        .pend_cnt_next   (cls_cnt),
        .pend_bytes_next (cls_bytes)
    );

    // next state
    always_comb begin
        m_xfer = m_tvalid && m_tready;

        // last byte of the current phase is on the output
        case (phase_reg)
            jse_pkg::PH_OPEN:  phase_end = 1'b1;
            jse_pkg::PH_FFFD:  phase_end = (chr_reg == jse_pkg::FFFD_LAST) &&
                                           (rep_reg + 3'd1 == desc_reg.nf);
            jse_pkg::PH_TAIL:  phase_end = (chr_reg + 3'd1 == desc_reg.tail_len);
            jse_pkg::PH_CLOSE: phase_end = 1'b1;
            default:           phase_end = 1'b0;
        endcase
        phase_after = jse_pkg::next_phase(desc_reg, phase_reg);

        // output stage takes the next descriptor when empty or finishing
        load = a_valid_reg && ((phase_reg == jse_pkg::PH_IDLE) ||
               (m_xfer && phase_end && phase_after == jse_pkg::PH_IDLE));

        s_tready     = !a_valid_reg || load;
        s_xfer       = s_tvalid && s_tready;
        a_valid_next = s_xfer || (a_valid_reg && !load);
        a_item_next  = a_item_reg;
        if (s_xfer) begin
            a_item_next.data_byte    = s_tdata;
            a_item_next.has_byte     = s_tuser[0];
            a_item_next.string_start = s_tuser[1];
            a_item_next.string_end   = s_tlast;
        end

        desc_next       = desc_reg;
        phase_next      = phase_reg;
        rep_next        = rep_reg;
        chr_next        = chr_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_bytes_next = pend_bytes_reg;

        if (load) begin
            desc_next       = cls_desc;
            phase_next      = jse_pkg::next_phase(cls_desc, jse_pkg::PH_IDLE);
            rep_next        = 3'd0;
            chr_next        = 3'd0;
            pend_cnt_next   = cls_cnt;
            pend_bytes_next = cls_bytes;
        end else if (m_xfer && phase_end) begin
            phase_next = phase_after;
            rep_next   = 3'd0;
            chr_next   = 3'd0;
        end else if (m_xfer) begin
            // replacement text repeats every six characters
            if (phase_reg == jse_pkg::PH_FFFD && chr_reg == jse_pkg::FFFD_LAST) begin
                chr_next = 3'd0;
                rep_next = rep_reg + 3'd1;
            end else begin
                chr_next = chr_reg + 3'd1;
            end
        end
    end

    // outputs
    always_comb begin
        m_tvalid = (phase_reg != jse_pkg::PH_IDLE);
        m_tlast  = (phase_reg == jse_pkg::PH_CLOSE);
        case (phase_reg)
            jse_pkg::PH_OPEN:  m_tdata = jse_pkg::CH_QUOTE;
            jse_pkg::PH_CLOSE: m_tdata = jse_pkg::CH_QUOTE;
            jse_pkg::PH_FFFD:  m_tdata = jse_pkg::fffd_char(chr_reg);
            jse_pkg::PH_TAIL: begin
                case (chr_reg)
                    3'd0:    m_tdata = desc_reg.tail[0];
                    3'd1:    m_tdata = desc_reg.tail[1];
                    3'd2:    m_tdata = desc_reg.tail[2];
                    3'd3:    m_tdata = desc_reg.tail[3];
                    3'd4:    m_tdata = desc_reg.tail[4];
                    3'd5:    m_tdata = desc_reg.tail[5];
                    default: m_tdata = 8'h00;
                endcase
            end
            default:           m_tdata = 8'h00;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            phase_reg    <= jse_pkg::PH_IDLE;
            rep_reg      <= 3'd0;
            chr_reg      <= 3'd0;
            pend_cnt_reg <= 2'd0;
        end else begin
            a_valid_reg  <= a_valid_next;
            phase_reg    <= phase_next;
            rep_reg      <= rep_next;
            chr_reg      <= chr_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        a_item_reg     <= a_item_next;
        desc_reg       <= desc_next;
        pend_bytes_reg <= pend_bytes_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jse_checker.sv
// ----------------------------------------------------------------------------
// jse_checker - port level checks of the json string escaper
// watches the stream ports for reset behaviour, stalls and flow
// ----------------------------------------------------------------------------
`default_nettype none

module jse_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // nothing to send straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // input side open straight after reset
    assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // an empty output stage never holds back the input
    assert property (@(posedge aclk) disable iff (!aresetn) !m_tvalid |-> s_tready)
        else $error("input stalled while output idle");

    // stalled output transfer holds its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed during stall");

endmodule

bind json_string_escaper_utf8 jse_checker u_jse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
